// File: rtl/core/ipacl_pkg.sv
// ipacl_pkg: shared constants, types and helpers of the IPv4 first-match ACL.
// Used by ipacl_rule_mem, ipacl_seq and the top level; depends on nothing.
package ipacl_pkg;

  localparam int MAX_RULES = 64;
  localparam int ADDR_BITS = 32;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = $clog2(MAX_RULES);
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [ADDR_BITS-1:0] mask;
    logic [ADDR_BITS-1:0] prefix;
  } rule_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    rule_t            wr_rule;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } mem_req_t;

  function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] len_sat;
    len_sat = (len > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS) : len;
    return ~({ADDR_BITS{1'b1}} >> len_sat);
  endfunction

endpackage

// File: rtl/core/ipacl_rule_mem.sv
// ipacl_rule_mem: rule table, one write port and one registered read port.
// Depends on ipacl_pkg.
module ipacl_rule_mem (
  input  logic              clk,
  input  ipacl_pkg::mem_req_t req,
  output ipacl_pkg::rule_t  rd_rule
);
  import ipacl_pkg::*;

  rule_t mem [MAX_RULES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_rule;
    end
    if (req.rd_en) begin
      rd_rule <= mem[req.rd_idx];
    end
  end

endmodule

// File: rtl/core/ipacl_seq.sv
// ipacl_seq: command sequencer, rule count and the shared prefix compare unit.
// Depends on ipacl_pkg; drives ipacl_rule_mem through a mem_req_t.
module ipacl_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [ipacl_pkg::ADDR_BITS-1:0] address,
  input  logic [ipacl_pkg::LEN_W-1:0]     prefix_len,
  input  logic                            allow,
  input  logic                            no_match_action,
  output ipacl_pkg::mem_req_t             req,
  input  ipacl_pkg::rule_t                rd_rule,
  output logic                            done,
  output logic                            permitted,
  output logic                            matched,
  output logic [5:0]                      rule_index,
  output logic                            table_full
);
  import ipacl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     issue;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 cmp_vld;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 hit;
  logic                 last;
  logic                 can_issue;
  logic                 full;

  assign busy      = (state == S_SCAN);
  assign full      = (count == CNT_W'(MAX_RULES));
  assign can_issue = (issue < count);
  assign hit       = cmp_vld && ((addr_q & rd_rule.mask) == rd_rule.prefix);
  assign last      = cmp_vld && ((CNT_W'(cmp_idx) + CNT_W'(1)) == count);

  always_comb begin
    req.wr_en          = (state == S_IDLE) && start && (op == OP_ADD) && !full;
    req.wr_idx         = count[IDX_W-1:0];
    req.wr_rule.action = allow;
    req.wr_rule.mask   = prefix_mask(prefix_len);
    req.wr_rule.prefix = address & prefix_mask(prefix_len);
    req.rd_en          = (state == S_SCAN) && can_issue;
    req.rd_idx         = issue[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      issue   <= '0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (op == OP_ADD) begin
              done       <= 1'b1;
              permitted  <= 1'b0;
              matched    <= 1'b0;
              table_full <= full;
              rule_index <= full ? 6'd0 : 6'(count);
              if (!full) begin
                count <= count + CNT_W'(1);
              end
            end else begin
              addr_q  <= address;
              issue   <= '0;
              cmp_vld <= 1'b0;
              if (count == '0) begin
                done       <= 1'b1;
                permitted  <= no_match_action;
                matched    <= 1'b0;
                rule_index <= 6'd0;
                table_full <= 1'b0;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (hit || last) begin
            done       <= 1'b1;
            permitted  <= hit ? rd_rule.action : no_match_action;
            matched    <= hit;
            rule_index <= hit ? 6'(cmp_idx) : 6'd0;
            table_full <= 1'b0;
            cmp_vld    <= 1'b0;
            state      <= S_IDLE;
          end else begin
            cmp_vld <= can_issue;
            cmp_idx <= issue[IDX_W-1:0];
            if (can_issue) begin
              issue <= issue + CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/ip_prefix_acl_first_match_top.sv
// Top level of the IPv4 first-match ACL: default-action register, sequencer, rule table.
// For an add beat done rises in the cycle after start; busy stays low.
// A check compares the stored rules in order, stopping at the first match or the last rule;
// an empty table gives done without a scan. busy falls as done rises.
// The receiver cannot stall. Synchronous reset empties the table and sets the default to allow.
// Depends on ipacl_pkg, ipacl_seq and ipacl_rule_mem.
module ip_prefix_acl_first_match_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] address,
  input  logic [5:0]  prefix_len,
  input  logic        allow,
  output logic        done,
  output logic        permitted,
  output logic        matched,
  output logic [5:0]  rule_index,
  output logic        table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import ipacl_pkg::*;

  logic     no_match_action;
  mem_req_t req;
  rule_t    rd_rule;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_match_action <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      no_match_action <= cfg_data;
    end
  end

  ipacl_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .address         (address),
    .prefix_len      (prefix_len),
    .allow           (allow),
    .no_match_action (no_match_action),
    .req             (req),
    .rd_rule         (rd_rule),
    .done            (done),
    .permitted       (permitted),
    .matched         (matched),
    .rule_index      (rule_index),
    .table_full      (table_full)
  );

  ipacl_rule_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_rule (rd_rule)
  );

endmodule

// File: rtl/core/ipacl_checker.sv
// ipacl_checker: port-level assertions for the first-match ACL, bound to the top level.
// Depends on ip_prefix_acl_first_match_top ports only.
module ipacl_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       op,
  input logic       done,
  input logic       permitted,
  input logic       matched,
  input logic [5:0] rule_index,
  input logic       table_full
);

  a_add_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !op |=> done && !busy)
    else $error("add beat did not complete in one cycle");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> !permitted && !matched && rule_index == 6'd0)
    else $error("rejected add carries a non-zero result");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !start && !busy |=> !done)
    else $error("done without a beat in flight");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && $past(op))
    else $error("busy rose without an accepted check beat");

endmodule

bind ip_prefix_acl_first_match_top ipacl_checker u_chk (.*);
